### rtl/noek_pkg.sv
package noek_pkg;

  localparam int ROUND_COUNT_DEFAULT = 16;
  localparam int WORD_W = 32;
  localparam int RC_IDX_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 2'd3;

  localparam logic OP_ENCRYPT = 1'b0;

  typedef logic [3:0][WORD_W-1:0] block_t;

  typedef struct packed {
    logic   op;
    block_t w;
  } stage_t;

  function automatic logic [7:0] rc(input logic [RC_IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      5'd0:    c = 8'h80;
      5'd1:    c = 8'h1B;
      5'd2:    c = 8'h36;
      5'd3:    c = 8'h6C;
      5'd4:    c = 8'hD8;
      5'd5:    c = 8'hAB;
      5'd6:    c = 8'h4D;
      5'd7:    c = 8'h9A;
      5'd8:    c = 8'h2F;
      5'd9:    c = 8'h5E;
      5'd10:   c = 8'hBC;
      5'd11:   c = 8'h63;
      5'd12:   c = 8'hC6;
      5'd13:   c = 8'h97;
      5'd14:   c = 8'h35;
      5'd15:   c = 8'h6A;
      5'd16:   c = 8'hD4;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] x, input int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] t);
    return t ^ rol(t, 24) ^ rol(t, 8);
  endfunction

  function automatic block_t theta(input block_t s, input block_t k);
    block_t r;
    logic [WORD_W-1:0] t;
    r = s;
    t = mix(r[0] ^ r[2]);
    r[1] = r[1] ^ t;
    r[3] = r[3] ^ t;
    r = r ^ k;
    t = mix(r[1] ^ r[3]);
    r[0] = r[0] ^ t;
    r[2] = r[2] ^ t;
    return r;
  endfunction

  function automatic block_t gamma_layer(input block_t s);
    block_t r;
    logic [WORD_W-1:0] t;
    r = s;
    r[1] = r[1] ^ ~(r[3] | r[2]);
    r[0] = r[0] ^ (r[2] & r[1]);
    t = r[3];
    r[3] = r[0];
    r[0] = t;
    r[2] = r[2] ^ r[0] ^ r[1] ^ r[3];
    r[1] = r[1] ^ ~(r[3] | r[2]);
    r[0] = r[0] ^ (r[2] & r[1]);
    return r;
  endfunction

  function automatic block_t one_round(input block_t s, input block_t k,
                                       input logic [7:0] c_pre, input logic [7:0] c_post);
    block_t r;
    r = s;
    r[0] = r[0] ^ {24'd0, c_pre};
    r = theta(r, k);
    r[0] = r[0] ^ {24'd0, c_post};
    r[1] = rol(r[1], 1);
    r[2] = rol(r[2], 5);
    r[3] = rol(r[3], 2);
    r = gamma_layer(r);
    r[1] = rol(r[1], 31);
    r[2] = rol(r[2], 27);
    r[3] = rol(r[3], 30);
    return r;
  endfunction

endpackage

### rtl/noek_round.sv
module noek_round #(
  parameter int ROUND_COUNT = noek_pkg::ROUND_COUNT_DEFAULT,
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  noek_pkg::block_t key,
  input  noek_pkg::block_t wkey,
  input  logic             up_valid,
  output logic             up_ready,
  input  noek_pkg::stage_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output noek_pkg::stage_t dn_data
);

  localparam logic [noek_pkg::RC_IDX_W-1:0] ENC_IDX = noek_pkg::RC_IDX_W'(STAGE);
  localparam logic [noek_pkg::RC_IDX_W-1:0] DEC_IDX =
    noek_pkg::RC_IDX_W'(ROUND_COUNT - STAGE);

  logic             valid;
  noek_pkg::stage_t data;
  noek_pkg::stage_t data_next;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    data_next.op = up_data.op;
    if (up_data.op == noek_pkg::OP_ENCRYPT) begin
      data_next.w = noek_pkg::one_round(up_data.w, key, noek_pkg::rc(ENC_IDX), 8'h00);
    end else begin
      data_next.w = noek_pkg::one_round(up_data.w, wkey, 8'h00, noek_pkg::rc(DEC_IDX));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

### rtl/noek_final.sv
module noek_final #(
  parameter int ROUND_COUNT = noek_pkg::ROUND_COUNT_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  noek_pkg::block_t key,
  input  noek_pkg::block_t wkey,
  input  logic             up_valid,
  output logic             up_ready,
  input  noek_pkg::stage_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output noek_pkg::block_t dn_data
);

  localparam logic [noek_pkg::RC_IDX_W-1:0] LAST_IDX = noek_pkg::RC_IDX_W'(ROUND_COUNT);
  localparam logic [noek_pkg::RC_IDX_W-1:0] FIRST_IDX = '0;

  logic             valid;
  noek_pkg::block_t data;
  noek_pkg::block_t data_next;
  noek_pkg::block_t tmp;

  assign up_ready = !valid || dn_ready;

  always_comb begin
    tmp = up_data.w;
    if (up_data.op == noek_pkg::OP_ENCRYPT) begin
      tmp[0] = tmp[0] ^ {24'd0, noek_pkg::rc(LAST_IDX)};
      data_next = noek_pkg::theta(tmp, key);
    end else begin
      data_next = noek_pkg::theta(tmp, wkey);
      data_next[0] = data_next[0] ^ {24'd0, noek_pkg::rc(FIRST_IDX)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

### rtl/noekeon_block_cipher.sv
// An accepted input is registered by each round cell in turn and then by the final cell.
// Throughput: one block per cycle unless the output stalls; each round is a pipeline cell
// and a final cell applies the closing constant and theta.
// Ready passes back through every cell in the same cycle, and an empty cell always accepts,
// so bubbles are filled while the output waits.
// Reset clears every cell's valid flag and the four key registers to zero.
module noekeon_block_cipher #(
  parameter int ROUND_COUNT = noek_pkg::ROUND_COUNT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [127:0]                  s_axis_tdata,  // in_word0, in_word1, in_word2, in_word3
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata,  // out_word0 .. out_word3
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [noek_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [noek_pkg::WORD_W-1:0]   cfg_data
);

  noek_pkg::block_t key;
  noek_pkg::block_t wkey;

  logic             valid [ROUND_COUNT+1];
  logic             ready [ROUND_COUNT+1];
  noek_pkg::stage_t blk   [ROUND_COUNT+1];
  noek_pkg::block_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        noek_pkg::REG_KEY_WORD0: key[0] <= cfg_data;
        noek_pkg::REG_KEY_WORD1: key[1] <= cfg_data;
        noek_pkg::REG_KEY_WORD2: key[2] <= cfg_data;
        noek_pkg::REG_KEY_WORD3: key[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wkey = noek_pkg::theta(key, '0);

  assign valid[0]    = s_axis_tvalid;
  assign s_axis_tready = ready[0];
  assign blk[0].op   = s_axis_tuser;
  assign blk[0].w[0] = s_axis_tdata[31:0];
  assign blk[0].w[1] = s_axis_tdata[63:32];
  assign blk[0].w[2] = s_axis_tdata[95:64];
  assign blk[0].w[3] = s_axis_tdata[127:96];

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
    noek_round #(
      .ROUND_COUNT(ROUND_COUNT),
      .STAGE      (g)
    ) u_round (
      .clk     (clk),
      .rst     (rst),
      .key     (key),
      .wkey    (wkey),
      .up_valid(valid[g]),
      .up_ready(ready[g]),
      .up_data (blk[g]),
      .dn_valid(valid[g+1]),
      .dn_ready(ready[g+1]),
      .dn_data (blk[g+1])
    );
  end

  noek_final #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_final (
    .clk     (clk),
    .rst     (rst),
    .key     (key),
    .wkey    (wkey),
    .up_valid(valid[ROUND_COUNT]),
    .up_ready(ready[ROUND_COUNT]),
    .up_data (blk[ROUND_COUNT]),
    .dn_valid(m_axis_tvalid),
    .dn_ready(m_axis_tready),
    .dn_data (result)
  );

  assign m_axis_tdata = {result[3], result[2], result[1], result[0]};

endmodule

### sim/tb_noekeon_block_cipher.sv
`timescale 1ns / 100ps

module tb_noekeon_block_cipher;

  localparam int unsigned ROUNDS = noek_pkg::ROUND_COUNT_DEFAULT;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned PHASE_COUNT = 8;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic OP_DECRYPT = !noek_pkg::OP_ENCRYPT;

  typedef logic [3:0][31:0] quad_t;

  class cipher_checker;
    quad_t key;
    quad_t expected_blocks[$];
    int unsigned rounds;
    int unsigned mismatches;

    function new(int unsigned n);
      rounds = n;
      key = '0;
      mismatches = 0;
    endfunction

    static function logic [31:0] rotl(logic [31:0] x, int unsigned n);
      return (x << n) | (x >> (32 - n));
    endfunction

    static function logic [7:0] round_const(int unsigned i);
      logic [7:0] c;
      case (i)
        0:       c = 8'h80;
        1:       c = 8'h1B;
        2:       c = 8'h36;
        3:       c = 8'h6C;
        4:       c = 8'hD8;
        5:       c = 8'hAB;
        6:       c = 8'h4D;
        7:       c = 8'h9A;
        8:       c = 8'h2F;
        9:       c = 8'h5E;
        10:      c = 8'hBC;
        11:      c = 8'h63;
        12:      c = 8'hC6;
        13:      c = 8'h97;
        14:      c = 8'h35;
        15:      c = 8'h6A;
        16:      c = 8'hD4;
        default: c = 8'h00;
      endcase
      return c;
    endfunction

    static function quad_t theta_step(quad_t s, quad_t k);
      quad_t r;
      logic [31:0] t;
      r = s;
      t = r[0] ^ r[2];
      t = t ^ rotl(t, 24) ^ rotl(t, 8);
      r[1] = r[1] ^ t;
      r[3] = r[3] ^ t;
      r = r ^ k;
      t = r[1] ^ r[3];
      t = t ^ rotl(t, 24) ^ rotl(t, 8);
      r[0] = r[0] ^ t;
      r[2] = r[2] ^ t;
      return r;
    endfunction

    static function quad_t gamma_step(quad_t s);
      quad_t r;
      logic [31:0] t;
      r = s;
      r[1] = r[1] ^ ~(r[3] | r[2]);
      r[0] = r[0] ^ (r[2] & r[1]);
      t = r[3];
      r[3] = r[0];
      r[0] = t;
      r[2] = r[2] ^ r[0] ^ r[1] ^ r[3];
      r[1] = r[1] ^ ~(r[3] | r[2]);
      r[0] = r[0] ^ (r[2] & r[1]);
      return r;
    endfunction

    static function quad_t round_step(quad_t s, quad_t k, logic [7:0] c_in, logic [7:0] c_out);
      quad_t r;
      r = s;
      r[0] = r[0] ^ {24'd0, c_in};
      r = theta_step(r, k);
      r[0] = r[0] ^ {24'd0, c_out};
      r[1] = rotl(r[1], 1);
      r[2] = rotl(r[2], 5);
      r[3] = rotl(r[3], 2);
      r = gamma_step(r);
      r[1] = rotl(r[1], 31);
      r[2] = rotl(r[2], 27);
      r[3] = rotl(r[3], 30);
      return r;
    endfunction

    function quad_t predict_block(logic op, quad_t blk);
      quad_t s;
      quad_t k;
      s = blk;
      k = key;
      if (op == noek_pkg::OP_ENCRYPT) begin
        for (int unsigned i = 0; i < rounds; i++) s = round_step(s, k, round_const(i), 8'h00);
        s[0] = s[0] ^ {24'd0, round_const(rounds)};
        s = theta_step(s, k);
      end else begin
        // The working key for decryption is the key passed through theta with a null key.
        k = theta_step(k, '0);
        for (int unsigned i = rounds; i > 0; i--) s = round_step(s, k, 8'h00, round_const(i));
        s = theta_step(s, k);
        s[0] = s[0] ^ {24'd0, round_const(0)};
      end
      return s;
    endfunction

    function void set_key(int unsigned idx, logic [31:0] value);
      key[idx] = value;
    endfunction

    function quad_t note_block(logic op, quad_t blk);
      quad_t r;
      r = predict_block(op, blk);
      expected_blocks.push_back(r);
      return r;
    endfunction

    function int unsigned pending();
      return expected_blocks.size();
    endfunction

    task report(string what);
      if (mismatches < 100) $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_block(quad_t got);
      quad_t want;
      if (expected_blocks.size() == 0) begin
        report($sformatf("result %h with no block outstanding", got));
      end else begin
        want = expected_blocks.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[i] !== want[i]) begin
            report($sformatf("out_word%0d got %h, expected %h", i, got[i], want[i]));
          end
        end
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [noek_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [noek_pkg::WORD_W-1:0] cfg_data = '0;

  cipher_checker sb;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  quad_t last_out = '0;
  logic last_op = noek_pkg::OP_ENCRYPT;
  int unsigned cycles = 0;

  noekeon_block_cipher #(
    .ROUND_COUNT(ROUNDS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** noekeon_block_cipher: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_block(m_axis_tdata);
  end

  function automatic int unsigned pause_len(bit enabled);
    return enabled ? $urandom_range(0, 12) : 0;
  endfunction

  function automatic logic [noek_pkg::CFG_IDX_W-1:0] key_reg(int unsigned i);
    logic [noek_pkg::CFG_IDX_W-1:0] r;
    case (i)
      0:       r = noek_pkg::REG_KEY_WORD0;
      1:       r = noek_pkg::REG_KEY_WORD1;
      2:       r = noek_pkg::REG_KEY_WORD2;
      default: r = noek_pkg::REG_KEY_WORD3;
    endcase
    return r;
  endfunction

  function automatic quad_t edge_block();
    quad_t b;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0:       b[i] = '0;
        1:       b[i] = '1;
        2:       b[i] = 32'h1 << $urandom_range(0, 31);
        default: b[i] = $urandom;
      endcase
    end
    return b;
  endfunction

  function automatic quad_t random_block();
    quad_t b;
    for (int i = 0; i < 4; i++) b[i] = $urandom;
    return b;
  endfunction

  // The receiver draws a stall before each result and then holds ready until a transaction.
  initial begin
    int unsigned stall;
    forever begin
      stall = pause_len(rx_idle);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_block(input logic op, input quad_t blk);
    int unsigned gap;
    gap = pause_len(tx_idle);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= blk;
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    last_out = sb.note_block(op, blk);
    last_op = op;
  endtask

  task automatic drain_blocks();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_key(input quad_t k, input logic [3:0] mask);
    for (int unsigned i = 0; i < 4; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= key_reg(i);
        cfg_data <= k[i];
        do @(posedge clk); while (!cfg_ready);
        sb.set_key(i, k[i]);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    quad_t blk;
    quad_t new_key;
    logic [3:0] mask;
    logic op;
    int unsigned pick;

    sb = new(ROUNDS);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed blocks under the key left by reset.
    send_block(noek_pkg::OP_ENCRYPT, '0);
    send_block(OP_DECRYPT, '0);
    send_block(noek_pkg::OP_ENCRYPT, '1);
    send_block(OP_DECRYPT, '1);
    for (int i = 0; i < 4; i++) begin
      blk = '0;
      blk[i] = '1;
      send_block(noek_pkg::OP_ENCRYPT, blk);
      send_block(OP_DECRYPT, blk);
    end
    send_block(noek_pkg::OP_ENCRYPT, {4{32'h0000_0001}});
    send_block(OP_DECRYPT, {4{32'h8000_0000}});
    send_block(OP_DECRYPT, {4{32'hAAAA_AAAA}});
    send_block(noek_pkg::OP_ENCRYPT, {4{32'h5555_5555}});
    send_block(noek_pkg::OP_ENCRYPT, '0);
    send_block(OP_DECRYPT, last_out);
    drain_blocks();

    for (int unsigned ph = 1; ph <= PHASE_COUNT; ph++) begin
      mask = 4'hF;
      case (ph)
        1:       new_key = '1;
        3:       new_key = {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
        4:       begin
          new_key = random_block();
          mask = 4'b0100;
        end
        6:       new_key = '0;
        7:       new_key = {32'h0000_0001, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000};
        default: new_key = random_block();
      endcase
      write_key(new_key, mask);
      tx_idle = (ph % 3 != 2) && (ph != 7);
      rx_idle = (ph % 3 != 2) && (ph != 4);

      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 9);
        op = $urandom_range(0, 1);
        if (pick < 2) begin
          blk = edge_block();
        end else if (pick == 2) begin
          // Feed the previous result back through the inverse operation.
          blk = last_out;
          op = !last_op;
        end else begin
          blk = random_block();
        end
        send_block(op, blk);
        if (ph == 3 && n == PHASE_ITEMS / 2) drain_blocks();
      end
      drain_blocks();
    end

    repeat (ROUNDS + 8) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d blocks never returned", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("** noekeon_block_cipher: PASSED **");
    end else begin
      $display("** noekeon_block_cipher: FAILED **");
    end
    $finish;
  end

endmodule
